/* rtl/ssmr_pkg.sv */
// shared types and constants for the sliding slope momentum regime block
package ssmr_pkg;

    localparam logic [2:0] REGIME_INSUFF     = 3'd0;
    localparam logic [2:0] REGIME_ACCEL_BULL = 3'd1;
    localparam logic [2:0] REGIME_DECEL_BULL = 3'd2;
    localparam logic [2:0] REGIME_ACCEL_BEAR = 3'd3;
    localparam logic [2:0] REGIME_DECEL_BEAR = 3'd4;
    localparam logic [2:0] REGIME_NEUTRAL    = 3'd5;

    localparam logic [1:0] REG_WINDOW_LEN    = 2'd0;
    localparam logic [1:0] REG_ACCEL_LEN     = 2'd1;
    localparam logic [1:0] REG_NEUTRAL_LEVEL = 2'd2;
    localparam logic [1:0] REG_ACCEL_LEVEL   = 2'd3;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic clear;
        logic add;
        logic walk_start;
        logic walk_sel;
        logic div_start;
        logic mom_store;
        logic acc_store;
        logic zero_accel;
        logic set_insuff;
        logic classify;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic sfill_ge2;
        logic mfill_ge2;
        logic walk_done;
        logic div_done;
    } status_t;

endpackage

/* rtl/ssmr_ctrl.sv */
// sequencer for one word: clear, or ring update, up to two slope walks and divisions, classify
module ssmr_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_command,
    output logic             in_ready,
    input  logic             out_free,
    input  ssmr_pkg::status_t st,
    output ssmr_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SWALK,
        S_SDIV,
        S_MCHECK,
        S_AWALK,
        S_ADIV,
        S_CLASS,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_command == ssmr_pkg::CMD_CLEAR)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.add    = 1'b1;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (st.sfill_ge2)
                begin
                    cmd.walk_start = 1'b1;
                    state_next     = S_SWALK;
                end
                else
                begin
                    cmd.set_insuff = 1'b1;
                    state_next     = S_DONE;
                end
            end
            S_SWALK:
            begin
                if (st.walk_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_SDIV;
                end
            end
            S_SDIV:
            begin
                if (st.div_done)
                begin
                    cmd.mom_store = 1'b1;
                    state_next    = S_MCHECK;
                end
            end
            S_MCHECK:
            begin
                if (st.mfill_ge2)
                begin
                    cmd.walk_start = 1'b1;
                    cmd.walk_sel   = 1'b1;
                    state_next     = S_AWALK;
                end
                else
                begin
                    cmd.zero_accel = 1'b1;
                    state_next     = S_CLASS;
                end
            end
            S_AWALK:
            begin
                if (st.walk_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_ADIV;
                end
            end
            S_ADIV:
            begin
                if (st.div_done)
                begin
                    cmd.acc_store = 1'b1;
                    state_next    = S_CLASS;
                end
            end
            S_CLASS:
            begin
                cmd.classify = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_walk_then_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWALK && st.walk_done) |=> (state_reg == S_SDIV))
        else $error("score walk did not hand over to division");

    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !out_free) |=> (state_reg == S_DONE))
        else $error("result left before output slot was free");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("ready raised while a word is in work");

endmodule

/* rtl/ssmr_dp.sv */
// datapath: score and momentum rings, multiply-accumulate walker, serial divider, regime logic
module ssmr_dp
#(
    parameter int WINDOW_MAX = 64,
    parameter int ACCEL_MAX  = 64,
    parameter int LW         = 7
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ssmr_pkg::cmd_t    cmd,
    output ssmr_pkg::status_t st,
    input  logic              len_wr,
    input  logic [LW-1:0]     w_eff,
    input  logic [LW-1:0]     a_eff,
    input  logic [30:0]       neutral_level,
    input  logic [30:0]       accel_level,
    input  logic signed [15:0] score,
    output logic [31:0]       momentum_now,
    output logic [31:0]       accel_now,
    output logic [2:0]        regime_now,
    output logic [31:0]       sample_count
);

    localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int AAW   = (ACCEL_MAX > 1) ? $clog2(ACCEL_MAX) : 1;
    localparam int CW    = LW + 1;
    localparam int PW    = CW + 32;
    localparam int ACC_W = 33 + 2 * LW;
    localparam int SC_W  = ACC_W + 13;
    localparam int NUM_W = SC_W + 1;
    localparam int DW    = 3 * LW + 1;
    localparam int QCW   = $clog2(NUM_W + 1);

    logic signed [15:0] score_mem [WINDOW_MAX];
    logic [31:0]        mom_mem [ACCEL_MAX];

    logic [LW-1:0] shead_reg;
    logic [LW-1:0] sfill_reg;
    logic [LW-1:0] mhead_reg;
    logic [LW-1:0] mfill_reg;
    logic [31:0]   mom_reg;
    logic [31:0]   acc_now_reg;
    logic [2:0]    regime_reg;
    logic [31:0]   count_reg;

    // walker
    logic                  walk_busy_reg;
    logic                  sel_reg;
    logic [LW-1:0]         n_reg;
    logic [LW-1:0]         len_reg;
    logic [LW-1:0]         ptr_reg;
    logic [LW-1:0]         cnt_reg;
    logic signed [CW-1:0]  c_reg;
    logic signed [CW-1:0]  c1_reg;
    logic                  v1_reg;
    logic                  v2_reg;
    logic signed [15:0]    srd_reg;
    logic [31:0]           mrd_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [ACC_W-1:0] sum_reg;
    logic [2*LW-1:0]       sq_reg;
    logic [DW-1:0]         d_reg;

    // divider
    logic                  div_busy_reg;
    logic                  neg_reg;
    logic [NUM_W-1:0]      num_reg;
    logic [NUM_W-1:0]      q_reg;
    logic [DW-1:0]         den_reg;
    logic [DW-1:0]         rem_reg;
    logic [QCW-1:0]        dcnt_reg;

    logic                  walk_done;
    logic                  div_done;
    logic [LW-1:0]         start_ptr;
    logic [LW-1:0]         start_n;
    logic [LW-1:0]         start_len;
    logic signed [31:0]    y_cur;
    logic signed [SC_W-1:0] scaled;
    logic [SC_W-1:0]       mag;
    logic [NUM_W-1:0]      num_init;
    logic [DW:0]           trial;
    logic [31:0]           slope_sat;
    logic [32:0]           m_ext;
    logic [32:0]           a_ext;
    logic [32:0]           m_mag;
    logic [32:0]           nt_ext;
    logic [32:0]           at_ext;
    logic [2:0]            regime_class;

    assign walk_done = walk_busy_reg && (cnt_reg == '0) && !v1_reg && !v2_reg;
    assign div_done  = div_busy_reg && (dcnt_reg == '0);

    assign st.sfill_ge2 = (sfill_reg >= LW'(2));
    assign st.mfill_ge2 = (mfill_reg >= LW'(2));
    assign st.walk_done = walk_done;
    assign st.div_done  = div_done;

    always_comb
    begin
        if (cmd.walk_sel)
        begin
            start_n   = mfill_reg;
            start_len = a_eff;
            start_ptr = (mfill_reg == a_eff) ? mhead_reg : '0;
        end
        else
        begin
            start_n   = sfill_reg;
            start_len = w_eff;
            start_ptr = (sfill_reg == w_eff) ? shead_reg : '0;
        end
    end

    assign y_cur = sel_reg ? $signed(mrd_reg) : 32'(srd_reg);

    // sum * 6 for momenta, sum * 6 * 1024 for scores
    always_comb
    begin
        if (sel_reg)
        begin
            scaled = (SC_W'(sum_reg) <<< 2) + (SC_W'(sum_reg) <<< 1);
        end
        else
        begin
            scaled = (SC_W'(sum_reg) <<< 12) + (SC_W'(sum_reg) <<< 11);
        end
        mag      = scaled[SC_W-1] ? SC_W'(-scaled) : SC_W'(scaled);
        num_init = {mag, 1'b0} + NUM_W'(d_reg);
    end

    assign trial = {rem_reg, num_reg[NUM_W-1]};

    always_comb
    begin
        if (neg_reg)
        begin
            if ((q_reg[NUM_W-1:32] != '0) || (q_reg[31] && (q_reg[30:0] != '0)))
            begin
                slope_sat = ssmr_pkg::SAT_MIN;
            end
            else
            begin
                slope_sat = 32'(-q_reg[31:0]);
            end
        end
        else
        begin
            if (q_reg[NUM_W-1:31] != '0)
            begin
                slope_sat = ssmr_pkg::SAT_MAX;
            end
            else
            begin
                slope_sat = q_reg[31:0];
            end
        end
    end

    always_comb
    begin
        m_ext  = {mom_reg[31], mom_reg};
        a_ext  = {acc_now_reg[31], acc_now_reg};
        m_mag  = mom_reg[31] ? 33'(-m_ext) : m_ext;
        nt_ext = {2'b00, neutral_level};
        at_ext = {2'b00, accel_level};
        if (m_mag < nt_ext)
        begin
            regime_class = ssmr_pkg::REGIME_NEUTRAL;
        end
        else if (!mom_reg[31] && (mom_reg != '0))
        begin
            regime_class = ($signed(a_ext) < -$signed(at_ext)) ?
                           ssmr_pkg::REGIME_DECEL_BULL : ssmr_pkg::REGIME_ACCEL_BULL;
        end
        else
        begin
            regime_class = ($signed(a_ext) > $signed(at_ext)) ?
                           ssmr_pkg::REGIME_DECEL_BEAR : ssmr_pkg::REGIME_ACCEL_BEAR;
        end
    end

    // ring memories
    always_ff @(posedge clk)
    begin
        if (cmd.add)
        begin
            score_mem[shead_reg[AW-1:0]] <= score;
        end
        if (cmd.mom_store)
        begin
            mom_mem[mhead_reg[AAW-1:0]] <= slope_sat;
        end
        srd_reg <= score_mem[ptr_reg[AW-1:0]];
        mrd_reg <= mom_mem[ptr_reg[AAW-1:0]];
    end

    // ring state and results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shead_reg   <= '0;
            sfill_reg   <= '0;
            mhead_reg   <= '0;
            mfill_reg   <= '0;
            mom_reg     <= '0;
            acc_now_reg <= '0;
            regime_reg  <= ssmr_pkg::REGIME_INSUFF;
            count_reg   <= '0;
        end
        else if (cmd.clear || len_wr)
        begin
            shead_reg   <= '0;
            sfill_reg   <= '0;
            mhead_reg   <= '0;
            mfill_reg   <= '0;
            mom_reg     <= '0;
            acc_now_reg <= '0;
            regime_reg  <= ssmr_pkg::REGIME_INSUFF;
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
        end
        else
        begin
            if (cmd.add)
            begin
                if (count_reg != 32'hFFFF_FFFF)
                begin
                    count_reg <= count_reg + 32'd1;
                end
                shead_reg <= (shead_reg == w_eff - LW'(1)) ? '0 : shead_reg + LW'(1);
                if (sfill_reg < w_eff)
                begin
                    sfill_reg <= sfill_reg + LW'(1);
                end
            end
            if (cmd.set_insuff)
            begin
                regime_reg <= ssmr_pkg::REGIME_INSUFF;
            end
            if (cmd.mom_store)
            begin
                mom_reg   <= slope_sat;
                mhead_reg <= (mhead_reg == a_eff - LW'(1)) ? '0 : mhead_reg + LW'(1);
                if (mfill_reg < a_eff)
                begin
                    mfill_reg <= mfill_reg + LW'(1);
                end
            end
            if (cmd.acc_store)
            begin
                acc_now_reg <= slope_sat;
            end
            if (cmd.zero_accel)
            begin
                acc_now_reg <= '0;
            end
            if (cmd.classify)
            begin
                regime_reg <= regime_class;
            end
        end
    end

    // walker control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_busy_reg <= 1'b0;
            cnt_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
            if (cmd.walk_start)
            begin
                walk_busy_reg <= 1'b1;
                cnt_reg       <= start_n;
                sel_reg       <= cmd.walk_sel;
                v1_reg        <= 1'b0;
            end
            else
            begin
                if (walk_done)
                begin
                    walk_busy_reg <= 1'b0;
                end
                v1_reg <= (cnt_reg != '0);
                if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - LW'(1);
                end
            end
        end
    end

    // walker data
    always_ff @(posedge clk)
    begin
        if (cmd.walk_start)
        begin
            n_reg   <= start_n;
            len_reg <= start_len;
            ptr_reg <= start_ptr;
            c_reg   <= CW'(1) - $signed({1'b0, start_n});
            sum_reg <= '0;
        end
        else
        begin
            if (cnt_reg != '0)
            begin
                ptr_reg <= (ptr_reg == len_reg - LW'(1)) ? '0 : ptr_reg + LW'(1);
                c_reg   <= c_reg + CW'(2);
            end
            if (v2_reg)
            begin
                sum_reg <= sum_reg + ACC_W'(prod_reg);
            end
        end
        c1_reg   <= c_reg;
        prod_reg <= $signed(c1_reg) * y_cur;
        sq_reg   <= ({{LW{1'b0}}, n_reg} * {{LW{1'b0}}, n_reg}) - (2*LW)'(1);
        d_reg    <= {{(DW-2*LW){1'b0}}, sq_reg} * {{(DW-LW){1'b0}}, n_reg};
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            dcnt_reg     <= '0;
        end
        else if (cmd.div_start)
        begin
            div_busy_reg <= 1'b1;
            dcnt_reg     <= QCW'(NUM_W);
        end
        else if (div_done)
        begin
            div_busy_reg <= 1'b0;
        end
        else if (dcnt_reg != '0)
        begin
            dcnt_reg <= dcnt_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            neg_reg <= scaled[SC_W-1];
            num_reg <= num_init;
            den_reg <= {d_reg[DW-2:0], 1'b0};
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (dcnt_reg != '0)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= DW'(trial - {1'b0, den_reg});
                q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[DW-1:0];
                q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign momentum_now = mom_reg;
    assign accel_now    = acc_now_reg;
    assign regime_now   = regime_reg;
    assign sample_count = count_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(walk_busy_reg && div_busy_reg))
        else $error("walker and divider busy together");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (sfill_reg <= w_eff) && (mfill_reg <= a_eff) || $past(len_wr))
        else $error("ring fill beyond its length");

    a_insuff_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.set_insuff) && !$past(len_wr) |-> (regime_reg == ssmr_pkg::REGIME_INSUFF))
        else $error("insufficient regime not taken");

endmodule

/* rtl/sliding_slope_momentum_regime_core.sv */
// top level: config registers, output register, controller and datapath
//
// channel  | signals                          | payload
// s_axis   | s_tvalid s_tready s_tdata s_tuser | score, command
// m_axis   | m_tvalid m_tready m_tdata         | momentum, accel, regime, reversal, total
// apb      | psel penable pwrite paddr ...     | four registers at 4*i
//
// a clear word goes from idle straight to done, a word with under two scores through the check state to done
// an add word walks the score ring and divides, then, with two momenta or more, walks the momentum
// ring and divides again, with a one-bit-per-cycle divider and one-entry-per-cycle ring walks
// one word is in work at a time; the next is taken once the result sits in the output register
// reset empties both rings at once through their fill counts, no clearing pass
module sliding_slope_momentum_regime_core
#(
    parameter int WINDOW_MAX = 64,
    parameter int ACCEL_MAX  = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // score
    input  logic         s_tuser,   // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // momentum_out, accel_out, regime_code, reversal_flag, sample_total
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int LW = $clog2(WINDOW_MAX + 1);

    logic [6:0]  window_len_reg;
    logic [6:0]  accel_len_reg;
    logic [30:0] neutral_level_reg;
    logic [30:0] accel_level_reg;
    logic        m_tvalid_reg;
    logic [103:0] m_tdata_reg;

    logic        cfg_wr;
    logic [1:0]  cfg_idx;
    logic        len_wr;
    logic [LW-1:0] w_eff;
    logic [LW-1:0] a_eff;
    logic [LW+6:0] w_wide;
    logic [LW+6:0] a_wide;

    ssmr_pkg::cmd_t    cmd;
    ssmr_pkg::status_t st;

    logic [31:0] momentum_now;
    logic [31:0] accel_now;
    logic [2:0]  regime_now;
    logic [31:0] sample_count;
    logic        reversal;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign len_wr  = cfg_wr && ((cfg_idx == ssmr_pkg::REG_WINDOW_LEN) ||
                                (cfg_idx == ssmr_pkg::REG_ACCEL_LEN));

    always_comb
    begin
        unique case (cfg_idx)
            ssmr_pkg::REG_WINDOW_LEN:    prdata = {25'd0, window_len_reg};
            ssmr_pkg::REG_ACCEL_LEN:     prdata = {25'd0, accel_len_reg};
            ssmr_pkg::REG_NEUTRAL_LEVEL: prdata = {1'b0, neutral_level_reg};
            ssmr_pkg::REG_ACCEL_LEVEL:   prdata = {1'b0, accel_level_reg};
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg    <= 7'd32;
            accel_len_reg     <= 7'd8;
            neutral_level_reg <= 31'd167772;
            accel_level_reg   <= 31'd167772;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                ssmr_pkg::REG_WINDOW_LEN:    window_len_reg    <= pwdata[6:0];
                ssmr_pkg::REG_ACCEL_LEN:     accel_len_reg     <= pwdata[6:0];
                ssmr_pkg::REG_NEUTRAL_LEVEL: neutral_level_reg <= pwdata[30:0];
                ssmr_pkg::REG_ACCEL_LEVEL:   accel_level_reg   <= pwdata[30:0];
                default:                     ;
            endcase
        end
    end

    // effective lengths
    always_comb
    begin
        w_wide = (LW+7)'(window_len_reg);
        if (w_wide == '0)
        begin
            w_wide = (LW+7)'(1);
        end
        if (w_wide > (LW+7)'(WINDOW_MAX))
        begin
            w_wide = (LW+7)'(WINDOW_MAX);
        end
        a_wide = (LW+7)'(accel_len_reg);
        if (a_wide == '0)
        begin
            a_wide = (LW+7)'(1);
        end
        if (a_wide > (LW+7)'(ACCEL_MAX))
        begin
            a_wide = (LW+7)'(ACCEL_MAX);
        end
        if (a_wide > w_wide)
        begin
            a_wide = w_wide;
        end
        w_eff = w_wide[LW-1:0];
        a_eff = a_wide[LW-1:0];
    end

    ssmr_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_command (s_tuser),
        .in_ready   (s_tready),
        .out_free   (!m_tvalid_reg || m_tready),
        .st         (st),
        .cmd        (cmd)
    );

    ssmr_dp
    #(
        .WINDOW_MAX (WINDOW_MAX),
        .ACCEL_MAX  (ACCEL_MAX),
        .LW         (LW)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .len_wr        (len_wr),
        .w_eff         (w_eff),
        .a_eff         (a_eff),
        .neutral_level (neutral_level_reg),
        .accel_level   (accel_level_reg),
        .score         ($signed(s_tdata)),
        .momentum_now  (momentum_now),
        .accel_now     (accel_now),
        .regime_now    (regime_now),
        .sample_count  (sample_count)
    );

    assign reversal = (regime_now == ssmr_pkg::REGIME_DECEL_BULL) ||
                      (regime_now == ssmr_pkg::REGIME_DECEL_BEAR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            m_tdata_reg <= {4'd0, sample_count, reversal, regime_now, accel_now, momentum_now};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word taken while one is in work");

    a_reversal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[67] == ((m_tdata[66:64] == ssmr_pkg::REGIME_DECEL_BULL) ||
                                      (m_tdata[66:64] == ssmr_pkg::REGIME_DECEL_BEAR))))
        else $error("reversal flag disagrees with regime");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over an untaken one");

endmodule
